[sv/gcd_pkg.sv]
// gcd_pkg: shared types and constants for the great-circle distance pipeline.
// No dependencies; every other file refers to it by scoped names.
package gcd_pkg;

  // field widths
  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int DIST_W = 26;
  localparam int RAD_W  = 16;

  // degree difference operand and result widths
  localparam int OPD_W = 25;
  localparam int DIF_W = 26;

  // datapath widths
  localparam int ANG_W  = 32;  // binary angle, one turn = 2^32
  localparam int SC_W   = 32;  // Q30 sine/cosine
  localparam int Z_W    = 33;  // residual angle in the rotation CORDIC
  localparam int VEC_W  = 33;  // vectoring CORDIC x/y/angle
  localparam int ROOT_W = 31;  // Q30 value in [0, 1], and its root
  localparam int RT_N_W = 2 * ROOT_W - 1;
  localparam int RT_R_W = RT_N_W + 1;

  localparam int DEG_HALF_TURN = 180;
  localparam int TWO           = 2;
  // degrees-to-turns: the divide by 360 becomes a divide by 45 after dropping three zero bits
  localparam int DEG_PRESHIFT = 3;
  localparam int DEG_DIV      = TWO * DEG_HALF_TURN / (1 << DEG_PRESHIFT);
  localparam int DEG_BIAS     = DEG_HALF_TURN / (1 << DEG_PRESHIFT);
  localparam int QUO_W        = 21;
  localparam int REM_W        = 7;
  localparam int IDX_W        = 6;
  localparam logic [26:0] DIV_RECIP = 27'((64'd1 << 32) / DEG_DIV);

  localparam logic [ROOT_W-1:0] Q30_ONE         = 31'h4000_0000;
  localparam logic [SC_W-1:0]   CORDIC_GAIN_INV = 32'h26DD_3B6A;
  localparam logic [29:0]       PI_Q28          = 30'd843314857;
  localparam logic [RAD_W-1:0]  RADIUS_RESET    = 16'd6371;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  // pipeline control handed to each datapath block
  typedef struct packed {
    logic adv;  // all stages advance
    logic vld;  // item entering the first stage
  } gcd_ctl_t;

endpackage

[sv/gcd_in_if.sv]
// gcd_in_if: input channel carrying one pair of points per item.
// Depends on gcd_pkg for field widths.
interface gcd_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [gcd_pkg::LAT_W-1:0] start_lat;
  logic signed [gcd_pkg::LON_W-1:0] start_lon;
  logic signed [gcd_pkg::LAT_W-1:0] end_lat;
  logic signed [gcd_pkg::LON_W-1:0] end_lon;

  modport source (output valid, start_lat, start_lon, end_lat, end_lon, input ready);
  modport sink   (input valid, start_lat, start_lon, end_lat, end_lon, output ready);
endinterface

[sv/gcd_out_if.sv]
// gcd_out_if: result channel carrying one distance per item.
// Depends on gcd_pkg for the field width.
interface gcd_out_if;
  logic                        valid;
  logic                        ready;
  logic [gcd_pkg::DIST_W-1:0]  arc_distance;

  modport source (output valid, arc_distance, input ready);
  modport sink   (input valid, arc_distance, output ready);
endinterface

[sv/gcd_turns.sv]
// gcd_turns: five-stage conversion of a degree difference (b - a) to a binary angle.
// Division by 360 uses a reciprocal multiply, one correction and a remainder table.
// Depends on gcd_pkg.
module gcd_turns #(
  parameter int SHIFT = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gcd_pkg::gcd_ctl_t                 ctl_i,
  input  logic signed [gcd_pkg::OPD_W-1:0]  a_i,
  input  logic signed [gcd_pkg::OPD_W-1:0]  b_i,
  output logic                              vld_o,
  output logic [gcd_pkg::ANG_W-1:0]         turns_o
);
  localparam int K  = SHIFT - gcd_pkg::DEG_PRESHIFT;
  localparam int DW = gcd_pkg::DIF_W;

  logic [K-1:0] frac_tbl [gcd_pkg::DEG_DIV];
  for (genvar g = 0; g < gcd_pkg::DEG_DIV; g++) begin : g_tbl
    assign frac_tbl[g] = K'((g * (1 << K) + gcd_pkg::DEG_BIAS) / gcd_pkg::DEG_DIV);
  end

  logic [4:0] vld_q;

  logic signed [DW-1:0]          d_q;
  logic [DW-1:0]                 m2_q, m3_q;
  logic                          neg2_q, neg3_q, neg4_q;
  logic [gcd_pkg::QUO_W-1:0]     aest_q, quo_q;
  logic [gcd_pkg::IDX_W-1:0]     rem_q;
  logic [gcd_pkg::ANG_W-1:0]     turns_q;

  logic [DW+26:0]                prod;
  logic [gcd_pkg::REM_W-1:0]     rem_raw, mul45;
  logic [63:0]                   quo_full;
  logic [gcd_pkg::ANG_W-1:0]     mag;

  assign prod    = (DW+27)'(m2_q) * (DW+27)'(gcd_pkg::DIV_RECIP);
  assign mul45   = gcd_pkg::REM_W'(aest_q[gcd_pkg::REM_W-1:0] *
                                   gcd_pkg::REM_W'(gcd_pkg::DEG_DIV));
  assign rem_raw = m3_q[gcd_pkg::REM_W-1:0] - mul45;
  assign quo_full = (64'(quo_q) << K) | 64'(frac_tbl[rem_q]);
  assign mag      = quo_full[gcd_pkg::ANG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.adv) begin
      vld_q <= {vld_q[3:0], ctl_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      d_q    <= DW'(b_i) - DW'(a_i);
      neg2_q <= d_q[DW-1];
      m2_q   <= d_q[DW-1] ? DW'(-d_q) : DW'(d_q);
      // estimate may be one low
      aest_q <= prod[DW+26:32];
      m3_q   <= m2_q;
      neg3_q <= neg2_q;
      if (rem_raw >= gcd_pkg::REM_W'(gcd_pkg::DEG_DIV)) begin
        quo_q <= aest_q + 1'b1;
        rem_q <= gcd_pkg::IDX_W'(rem_raw - gcd_pkg::REM_W'(gcd_pkg::DEG_DIV));
      end else begin
        quo_q <= aest_q;
        rem_q <= gcd_pkg::IDX_W'(rem_raw);
      end
      neg4_q  <= neg3_q;
      turns_q <= neg4_q ? (~mag + 1'b1) : mag;
    end
  end

  assign vld_o   = vld_q[4];
  assign turns_o = turns_q;
endmodule

[sv/gcd_sincos.sv]
// gcd_sincos: rotation-mode CORDIC, one iteration per stage, plus a sign output stage.
// Half-plane fold is applied ahead of the first iteration. Depends on gcd_pkg.
module gcd_sincos #(
  parameter int STEPS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gcd_pkg::gcd_ctl_t                ctl_i,
  input  logic [gcd_pkg::ANG_W-1:0]        angle_i,
  output logic                             vld_o,
  output logic signed [gcd_pkg::SC_W-1:0]  sin_o,
  output logic signed [gcd_pkg::SC_W-1:0]  cos_o
);
  localparam int CW = gcd_pkg::SC_W;
  localparam int ZW = gcd_pkg::Z_W;

  logic signed [CW-1:0] x_q [STEPS];
  logic signed [CW-1:0] y_q [STEPS];
  logic signed [ZW-1:0] z_q [STEPS];
  logic                 flip_q [STEPS];
  logic                 vld_q [STEPS];
  logic signed [CW-1:0] sin_q, cos_q;
  logic                 vout_q;

  logic                 flip0;
  logic signed [ZW-1:0] z0;

  // angles in the left half plane are turned by half a turn, result negated
  assign flip0 = angle_i[31] ^ angle_i[30];
  assign z0    = ZW'($signed({angle_i[31] ^ flip0, angle_i[30:0]}));

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic signed [CW-1:0] x_in, y_in, dx, dy;
    logic signed [ZW-1:0] z_in, at;
    logic                 f_in, v_in;

    if (i == 0) begin : g_first
      assign x_in = $signed(gcd_pkg::CORDIC_GAIN_INV);
      assign y_in = '0;
      assign z_in = z0;
      assign f_in = flip0;
      assign v_in = ctl_i.vld;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign f_in = flip_q[i-1];
      assign v_in = vld_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign at = $signed({1'b0, gcd_pkg::ATAN_TURNS[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (ctl_i.adv) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        flip_q[i] <= f_in;
        if (z_in >= 0) begin
          x_q[i] <= x_in - dx;
          y_q[i] <= y_in + dy;
          z_q[i] <= z_in - at;
        end else begin
          x_q[i] <= x_in + dx;
          y_q[i] <= y_in - dy;
          z_q[i] <= z_in + at;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vout_q <= vld_q[STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      sin_q <= flip_q[STEPS-1] ? -y_q[STEPS-1] : y_q[STEPS-1];
      cos_q <= flip_q[STEPS-1] ? -x_q[STEPS-1] : x_q[STEPS-1];
    end
  end

  assign vld_o = vout_q;
  assign sin_o = sin_q;
  assign cos_o = cos_q;
endmodule

[sv/gcd_isqrt.sv]
// gcd_isqrt: Q30 square root, restoring digit-by-digit, one result bit per stage.
// Depends on gcd_pkg.
module gcd_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gcd_pkg::gcd_ctl_t          ctl_i,
  input  logic [gcd_pkg::ROOT_W-1:0] val_i,
  output logic                       vld_o,
  output logic [gcd_pkg::ROOT_W-1:0] root_o
);
  localparam int NW    = gcd_pkg::RT_N_W;
  localparam int RW    = gcd_pkg::RT_R_W;
  localparam int STAGES = gcd_pkg::ROOT_W;

  logic [NW-1:0] n_q [STAGES];
  logic [RW-1:0] r_q [STAGES];
  logic          vld_q [STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    localparam logic [RW-1:0] BIT = RW'(1) << (NW - 1 - 2 * j);
    logic [NW-1:0] n_in;
    logic [RW-1:0] r_in, sum;
    logic          v_in;

    if (j == 0) begin : g_first
      assign n_in = {val_i, (gcd_pkg::ROOT_W - 1)'(0)};
      assign r_in = '0;
      assign v_in = ctl_i.vld;
    end else begin : g_next
      assign n_in = n_q[j-1];
      assign r_in = r_q[j-1];
      assign v_in = vld_q[j-1];
    end

    assign sum = r_in + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (ctl_i.adv) begin
        vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        if ({1'b0, n_in} >= sum) begin
          n_q[j] <= NW'({1'b0, n_in} - sum);
          r_q[j] <= (r_in >> 1) + BIT;
        end else begin
          n_q[j] <= n_in;
          r_q[j] <= r_in >> 1;
        end
      end
    end
  end

  assign vld_o  = vld_q[STAGES-1];
  assign root_o = r_q[STAGES-1][gcd_pkg::ROOT_W-1:0];
endmodule

[sv/gcd_atan.sv]
// gcd_atan: vectoring-mode CORDIC giving atan2(vy, vx) as a binary angle,
// one iteration per stage, clamped to [0, quarter turn] at the output. Depends on gcd_pkg.
module gcd_atan #(
  parameter int STEPS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gcd_pkg::gcd_ctl_t          ctl_i,
  input  logic [gcd_pkg::ROOT_W-1:0] vx_i,
  input  logic [gcd_pkg::ROOT_W-1:0] vy_i,
  output logic                       vld_o,
  output logic [gcd_pkg::ROOT_W-1:0] ang_o
);
  localparam int VW = gcd_pkg::VEC_W;

  logic signed [VW-1:0] x_q [STEPS];
  logic signed [VW-1:0] y_q [STEPS];
  logic signed [VW-1:0] a_q [STEPS];
  logic                 vld_q [STEPS];
  logic [gcd_pkg::ROOT_W-1:0] ang_q;
  logic                 vout_q;

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic signed [VW-1:0] x_in, y_in, a_in, dx, dy, at;
    logic                 v_in;

    if (i == 0) begin : g_first
      assign x_in = VW'(vx_i);
      assign y_in = VW'(vy_i);
      assign a_in = '0;
      assign v_in = ctl_i.vld;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign a_in = a_q[i-1];
      assign v_in = vld_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign at = $signed({1'b0, gcd_pkg::ATAN_TURNS[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (ctl_i.adv) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        if (y_in >= 0) begin
          x_q[i] <= x_in + dx;
          y_q[i] <= y_in - dy;
          a_q[i] <= a_in + at;
        end else begin
          x_q[i] <= x_in - dx;
          y_q[i] <= y_in + dy;
          a_q[i] <= a_in - at;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vout_q <= vld_q[STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      if (a_q[STEPS-1] < 0) begin
        ang_q <= '0;
      end else if (a_q[STEPS-1] > $signed(VW'(gcd_pkg::Q30_ONE))) begin
        ang_q <= gcd_pkg::Q30_ONE;
      end else begin
        ang_q <= a_q[STEPS-1][gcd_pkg::ROOT_W-1:0];
      end
    end
  end

  assign vld_o = vout_q;
  assign ang_o = ang_q;
endmodule

[sv/gcd_outbuf.sv]
// gcd_outbuf: two-entry output buffer (head register plus skid) for result items.
// Its room flag is registered and stalls the whole pipeline. Depends on gcd_pkg, gcd_out_if.
module gcd_outbuf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [gcd_pkg::DIST_W-1:0] dist_i,
  output logic                       room_o,
  gcd_out_if.source                  out_o
);
  logic [gcd_pkg::DIST_W-1:0] head_q, skid_q;
  logic                       head_vld_q, skid_vld_q;
  logic                       push, pop;

  assign room_o = !skid_vld_q;
  assign push   = vld_i && room_o;
  assign pop    = head_vld_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop && !push) begin
      head_vld_q <= skid_vld_q;
      skid_vld_q <= 1'b0;
    end else if (!pop && push) begin
      head_vld_q <= 1'b1;
      skid_vld_q <= head_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && push) begin
      head_q <= dist_i;
    end else if (pop) begin
      head_q <= skid_q;
    end else if (push && !head_vld_q) begin
      head_q <= dist_i;
    end
    if (push && head_vld_q && !pop) begin
      skid_q <= dist_i;
    end
  end

  assign out_o.valid        = head_vld_q;
  assign out_o.arc_distance = head_q;
endmodule

[sv/great_circle_distance.sv]
// Haversine great-circle distance, fully pipelined: one item accepted per cycle,
// except while stalled. Its depth comes mainly from the two CORDIC pipelines
// and the 31-stage root pipeline.
// The whole pipeline stalls only while both output buffer entries hold results.
// Reset empties the pipeline and buffer and loads the radius with 6371.
module great_circle_distance #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STEPS    = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  gcd_in_if.sink                    in_i,
  gcd_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [gcd_pkg::RAD_W-1:0] cfg_wdata_i
);
  localparam int HALF_SHIFT = 31 - ANGLE_FRAC_BITS;
  localparam int FULL_SHIFT = 32 - ANGLE_FRAC_BITS;
  localparam int OW = gcd_pkg::OPD_W;
  localparam int SW = gcd_pkg::SC_W;
  localparam int RW = gcd_pkg::ROOT_W;

  logic                 adv;
  gcd_pkg::gcd_ctl_t    in_ctl;
  logic [gcd_pkg::RAD_W-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= gcd_pkg::RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = adv;
  assign in_ctl     = '{adv: adv, vld: in_i.valid};

  // degree to angle conversion
  logic [3:0]                t_vld;
  logic [gcd_pkg::ANG_W-1:0] t_dlat, t_dlon, t_lat1, t_lat2;

  gcd_turns #(.SHIFT(HALF_SHIFT)) u_turns_dlat (
    .clk_i, .rst_ni, .ctl_i(in_ctl),
    .a_i(OW'(in_i.start_lat)), .b_i(OW'(in_i.end_lat)),
    .vld_o(t_vld[0]), .turns_o(t_dlat)
  );
  gcd_turns #(.SHIFT(HALF_SHIFT)) u_turns_dlon (
    .clk_i, .rst_ni, .ctl_i(in_ctl),
    .a_i(OW'(in_i.start_lon)), .b_i(OW'(in_i.end_lon)),
    .vld_o(t_vld[1]), .turns_o(t_dlon)
  );
  gcd_turns #(.SHIFT(FULL_SHIFT)) u_turns_lat1 (
    .clk_i, .rst_ni, .ctl_i(in_ctl),
    .a_i('0), .b_i(OW'(in_i.start_lat)),
    .vld_o(t_vld[2]), .turns_o(t_lat1)
  );
  gcd_turns #(.SHIFT(FULL_SHIFT)) u_turns_lat2 (
    .clk_i, .rst_ni, .ctl_i(in_ctl),
    .a_i('0), .b_i(OW'(in_i.end_lat)),
    .vld_o(t_vld[3]), .turns_o(t_lat2)
  );

  // sine and cosine
  logic [3:0]            sc_vld;
  logic signed [SW-1:0]  s_dlat, s_dlon, c_lat1, c_lat2;

  gcd_sincos #(.STEPS(CORDIC_STEPS)) u_sc_dlat (
    .clk_i, .rst_ni, .ctl_i('{adv: adv, vld: t_vld[0]}), .angle_i(t_dlat),
    .vld_o(sc_vld[0]), .sin_o(s_dlat), .cos_o()
  );
  gcd_sincos #(.STEPS(CORDIC_STEPS)) u_sc_dlon (
    .clk_i, .rst_ni, .ctl_i('{adv: adv, vld: t_vld[1]}), .angle_i(t_dlon),
    .vld_o(sc_vld[1]), .sin_o(s_dlon), .cos_o()
  );
  gcd_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat1 (
    .clk_i, .rst_ni, .ctl_i('{adv: adv, vld: t_vld[2]}), .angle_i(t_lat1),
    .vld_o(sc_vld[2]), .sin_o(), .cos_o(c_lat1)
  );
  gcd_sincos #(.STEPS(CORDIC_STEPS)) u_sc_lat2 (
    .clk_i, .rst_ni, .ctl_i('{adv: adv, vld: t_vld[3]}), .angle_i(t_lat2),
    .vld_o(sc_vld[3]), .sin_o(), .cos_o(c_lat2)
  );

  // haversine term h = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2)
  logic              m1_vld_q, m2_vld_q, m3_vld_q, m4_vld_q;
  logic [SW-1:0]     ys, zs;
  logic [63:0]       ysq, zsq;
  logic signed [63:0] pcc;
  logic [33:0]       y2_q, z2_q, y2b_q;
  logic signed [33:0] pc_q;
  logic signed [68:0] pz;
  logic signed [38:0] qs_q;
  logic signed [39:0] hs;
  logic [RW-1:0]     h_q, hv_q, hu_q;

  assign ys  = s_dlat[SW-1] ? SW'(-s_dlat) : SW'(s_dlat);
  assign zs  = s_dlon[SW-1] ? SW'(-s_dlon) : SW'(s_dlon);
  assign ysq = 64'(ys) * 64'(ys);
  assign zsq = 64'(zs) * 64'(zs);
  assign pcc = 64'(c_lat1) * 64'(c_lat2);
  assign pz  = 69'(pc_q) * 69'($signed({1'b0, z2_q}));
  assign hs  = 40'($signed({1'b0, y2b_q})) + 40'(qs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
      m3_vld_q <= 1'b0;
      m4_vld_q <= 1'b0;
    end else if (adv) begin
      m1_vld_q <= &sc_vld;
      m2_vld_q <= m1_vld_q;
      m3_vld_q <= m2_vld_q;
      m4_vld_q <= m3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y2_q  <= ysq[63:30];
      z2_q  <= zsq[63:30];
      pc_q  <= pcc[63:30];
      y2b_q <= y2_q;
      qs_q  <= pz[68:30];
      if (hs < 0) begin
        h_q <= '0;
      end else if (hs > $signed(40'(gcd_pkg::Q30_ONE))) begin
        h_q <= gcd_pkg::Q30_ONE;
      end else begin
        h_q <= hs[RW-1:0];
      end
      hv_q <= h_q;
      hu_q <= gcd_pkg::Q30_ONE - h_q;
    end
  end

  // roots and arc angle
  logic          rt_vld_u, rt_vld_v, at_vld;
  logic [RW-1:0] root_u, root_v, ang;

  gcd_isqrt u_root_x (
    .clk_i, .rst_ni, .ctl_i('{adv: adv, vld: m4_vld_q}), .val_i(hu_q),
    .vld_o(rt_vld_u), .root_o(root_u)
  );
  gcd_isqrt u_root_y (
    .clk_i, .rst_ni, .ctl_i('{adv: adv, vld: m4_vld_q}), .val_i(hv_q),
    .vld_o(rt_vld_v), .root_o(root_v)
  );

  gcd_atan #(.STEPS(CORDIC_STEPS)) u_atan (
    .clk_i, .rst_ni, .ctl_i('{adv: adv, vld: rt_vld_u & rt_vld_v}),
    .vx_i(root_u), .vy_i(root_v), .vld_o(at_vld), .ang_o(ang)
  );

  // distance = R * ang * pi / 2^22, pi in Q28, rounded
  logic        f1_vld_q, f2_vld_q, f3_vld_q;
  logic [46:0] t_q;
  logic [54:0] hip_q;
  logic [51:0] lop;
  logic [29:0] lop_q;
  logic [55:0] tot;
  logic [gcd_pkg::DIST_W-1:0] dist_q;

  assign lop = 52'(t_q[21:0]) * 52'(gcd_pkg::PI_Q28);
  assign tot = 56'(hip_q) + 56'(lop_q) + (56'(1) << 27);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
      f3_vld_q <= 1'b0;
    end else if (adv) begin
      f1_vld_q <= at_vld;
      f2_vld_q <= f1_vld_q;
      f3_vld_q <= f2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q    <= 47'(radius_q) * 47'(ang);
      hip_q  <= 55'(t_q[46:22]) * 55'(gcd_pkg::PI_Q28);
      lop_q  <= lop[51:22];
      dist_q <= tot[53:28];
    end
  end

  gcd_outbuf u_outbuf (
    .clk_i, .rst_ni, .vld_i(f3_vld_q), .dist_i(dist_q), .room_o(adv), .out_o
  );

  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |-> out_o.valid) else $error("pipeline stalled with no result waiting");

  a_front_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sc_vld[0] == sc_vld[1]) && (sc_vld[0] == sc_vld[2]) && (sc_vld[0] == sc_vld[3]))
    else $error("angle paths out of step");

  a_roots_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_vld_u == rt_vld_v) else $error("root pipelines out of step");

  a_h_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m3_vld_q |-> (h_q <= gcd_pkg::Q30_ONE)) else $error("h above one");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && f3_vld_q |=> out_o.valid) else $error("finished item not presented");
endmodule

[bench/gcd_checker.sv]
// gcd_checker: watches the point and distance channels of the great-circle
// distance block, predicts each distance and compares. Depends on gcd_pkg.
module gcd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  gcd_in_if           in_w,
  gcd_out_if          out_w,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  localparam int FRAC = 16;
  localparam int STEPS = 24;

  logic [gcd_pkg::RAD_W-1:0]    radius_q;
  logic [gcd_pkg::DIST_W-1:0]   dist_queue[$];

  function automatic logic [31:0] deg_to_turns(longint d, int sh);
    longint unsigned m, q;
    m = (d < 0) ? -d : d;
    q = ((m << sh) + 64'd180) / 64'd360;
    return (d < 0) ? 32'(0 - q[31:0]) : q[31:0];
  endfunction

  function automatic void rotate(input logic [31:0] a, output longint s, output longint c);
    bit flip;
    longint x, y, z, dx, dy;
    flip = 0;
    x = longint'(gcd_pkg::CORDIC_GAIN_INV);
    y = 0;
    if (32'(a + 32'h4000_0000) >= 32'h8000_0000) begin
      a = 32'(a - 32'h8000_0000);
      flip = 1;
    end
    z = longint'($signed(a));
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(gcd_pkg::ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(gcd_pkg::ATAN_TURNS[i]);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint half_sine_sq(longint d);
    longint s, c;
    longint unsigned m;
    rotate(deg_to_turns(d, 31 - FRAC), s, c);
    m = (s < 0) ? -s : s;
    return longint'((m * m) >> 30);
  endfunction

  function automatic longint root_q30(longint v);
    longint unsigned n, r, b;
    n = longint'(v) << 30;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [gcd_pkg::DIST_W-1:0] predict_distance(
      longint lat1, longint lon1, longint lat2, longint lon2, logic [15:0] rad);
    longint y, z, s1, c1, s2, c2, h, vx, vy, ang, dx, dy;
    longint unsigned t, hi, lo, tot;
    y = half_sine_sq(lat2 - lat1);
    z = half_sine_sq(lon2 - lon1);
    rotate(deg_to_turns(lat1, 32 - FRAC), s1, c1);
    rotate(deg_to_turns(lat2, 32 - FRAC), s2, c2);
    h = y + (((c1 * c2) >>> 30) * z >>> 30);
    if (h < 0) h = 0;
    if (h > (64'sd1 << 30)) h = 64'sd1 << 30;
    vx = root_q30((64'sd1 << 30) - h);
    vy = root_q30(h);
    ang = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx += dx; vy -= dy; ang += longint'(gcd_pkg::ATAN_TURNS[i]);
      end else begin
        vx -= dx; vy += dy; ang -= longint'(gcd_pkg::ATAN_TURNS[i]);
      end
    end
    if (ang < 0) ang = 0;
    if (ang > (64'sd1 << 30)) ang = 64'sd1 << 30;
    t = longint'(rad) * longint'(ang);
    hi = t >> 22;
    lo = t & ((64'd1 << 22) - 1);
    tot = hi * longint'(gcd_pkg::PI_Q28) + ((lo * longint'(gcd_pkg::PI_Q28)) >> 22);
    return gcd_pkg::DIST_W'((tot + (64'd1 << 27)) >> 28);
  endfunction

  assign pending_o = dist_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [gcd_pkg::DIST_W-1:0] want;
    if (!rst_ni) begin
      radius_q <= gcd_pkg::RADIUS_RESET;
      fail_count_o <= 0;
      dist_queue.delete();
    end else begin
      if (in_w.valid && in_w.ready)
        dist_queue.push_back(predict_distance(longint'(in_w.start_lat),
            longint'(in_w.start_lon), longint'(in_w.end_lat),
            longint'(in_w.end_lon), radius_q));
      if (out_w.valid && out_w.ready) begin
        if (dist_queue.size() == 0) begin
          $display("%0t: unexpected distance item %0d", $time, out_w.arc_distance);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = dist_queue.pop_front();
          if (want !== out_w.arc_distance) begin
            $display("%0t: arc_distance expected %0d actual %0d",
                     $time, want, out_w.arc_distance);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) radius_q <= cfg_wdata_i;
    end
  end
endmodule

[bench/great_circle_distance_tb.sv]
// great_circle_distance_tb: drives point pairs and radius settings into the
// block and gives the verdict. Depends on gcd_pkg, the channel interfaces, gcd_checker.
module great_circle_distance_tb;
  localparam int LATENCY = 94;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LAT_MAX = 5898240;
  localparam int LON_MAX = 11796480;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we = 0;
  logic [gcd_pkg::RAD_W-1:0] cfg_wdata = '0;
  bit quiet = 0;
  int fail_count, pending, cycles = 0;

  gcd_in_if  in_w ();
  gcd_out_if out_w ();

  great_circle_distance dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_w), .out_o(out_w),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata)
  );

  gcd_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_w(in_w), .out_w(out_w),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls in bursts
  int stall_left = 0;
  initial out_w.ready = 0;
  always @(negedge clk_i) begin
    bit rdy;
    if (stall_left > 0) begin
      stall_left--;
      rdy = 0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      rdy = 0;
    end else begin
      rdy = 1;
    end
    out_w.ready <= rdy;
  end

  task automatic send_points(int lat1, int lon1, int lat2, int lon2);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      in_w.valid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_w.valid <= 1;
    in_w.start_lat <= gcd_pkg::LAT_W'(lat1);
    in_w.start_lon <= gcd_pkg::LON_W'(lon1);
    in_w.end_lat <= gcd_pkg::LAT_W'(lat2);
    in_w.end_lon <= gcd_pkg::LON_W'(lon2);
    do @(posedge clk_i); while (!in_w.ready);
    @(negedge clk_i);
  endtask

  task automatic set_radius(logic [gcd_pkg::RAD_W-1:0] r);
    in_w.valid <= 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    cfg_we <= 1;
    cfg_wdata <= r;
    @(negedge clk_i);
    cfg_we <= 0;
  endtask

  function automatic int rand_lat();
    if ($urandom_range(0, 9) == 0) return int'($signed(gcd_pkg::LAT_W'($urandom)));
    return $urandom_range(0, 2 * LAT_MAX) - LAT_MAX;
  endfunction

  function automatic int rand_lon();
    if ($urandom_range(0, 9) == 0) return int'($signed(gcd_pkg::LON_W'($urandom)));
    return $urandom_range(0, 2 * LON_MAX) - LON_MAX;
  endfunction

  task automatic random_batch(int n);
    int la, lo;
    for (int i = 0; i < n; i++) begin
      la = rand_lat();
      lo = rand_lon();
      case ($urandom_range(0, 3))
        0: send_points(la, lo, la + $urandom_range(0, 2000) - 1000,
                       lo + $urandom_range(0, 2000) - 1000);
        1: send_points(la, lo, -la, lo + LON_MAX);
        default: send_points(la, lo, rand_lat(), rand_lon());
      endcase
    end
  endtask

  initial begin
    in_w.valid = 0;
    in_w.start_lat = '0;
    in_w.start_lon = '0;
    in_w.end_lat = '0;
    in_w.end_lon = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    set_radius(16'd6371);
    send_points(0, 0, 0, 0);
    send_points(LAT_MAX, 0, -LAT_MAX, 0);           // pole to pole
    send_points(0, 0, 0, LON_MAX);                  // antipodes on the equator
    send_points(0, -LON_MAX, 0, LON_MAX);
    send_points(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_points(-LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX);
    send_points(3276800, 1000, -3276800, 1000 + LON_MAX);
    send_points(1, 1, 0, 0);
    send_points(-1, -1, 1, 1);
    // out of range: angles wrap
    send_points(-(1 << 23), -(1 << 24), (1 << 23) - 1, (1 << 24) - 1);
    send_points((1 << 23) - 1, (1 << 24) - 1, -(1 << 23), -(1 << 24));
    send_points(0, 0, 0, 2 * LON_MAX);
    send_points(LAT_MAX, 0, LAT_MAX, 12345);
    send_points(-LAT_MAX, 555, LAT_MAX, 555);
    send_points(2949120, 2949120, -2949120, -8847360);
    random_batch(300);

    set_radius(16'd1);
    send_points(0, 0, 0, LON_MAX);
    random_batch(300);

    set_radius(16'd65535);
    send_points(0, 0, 0, LON_MAX);
    send_points(LAT_MAX, 0, -LAT_MAX, 0);
    random_batch(300);

    set_radius(16'd0);                             // zero radius gives zero
    send_points(0, 0, 0, LON_MAX);
    random_batch(100);

    set_radius(16'($urandom_range(1, 65535)));
    random_batch(300);

    set_radius(16'd6371);
    quiet = 1;
    random_batch(300);

    in_w.valid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
